[design/aoif_pkg.sv]
// package for the adc offset iir filter core: widths, reset values, register codes
// no dependencies; used by aoif_filter_step and adc_offset_iir_filter_core
package aoif_pkg;

	localparam int Q_FRAC_DEF      = 6;
	localparam int SAMPLE_BITS_DEF = 10;

	localparam int DATA_W   = 16;  // filter state and zero offset width
	localparam int ALPHA_W  = 7;   // weight register width
	localparam int OFFSET_W = 16;  // fixed channel c offset width
	localparam int APB_DW   = 32;
	localparam int APB_AW   = 4;

	localparam logic [ALPHA_W-1:0] MEAS_ALPHA_RST = 7'd8;
	localparam logic [ALPHA_W-1:0] ZERO_ALPHA_RST = 7'd1;
	localparam int                 ZERO_INT_RST   = 524;  // zero offset, integer part

	typedef enum logic [1:0] {
		REG_MEAS_ALPHA = 2'd0,
		REG_ZERO_ALPHA = 2'd1,
		REG_OFFSET_C   = 2'd2
	} reg_idx_t;

endpackage

[design/aoif_filter_step.sv]
// one step of a first-order exponential filter in fixed point, wraps to DATA_W bits
// depends on aoif_pkg
module aoif_filter_step #(
	parameter int Q_FRAC   = aoif_pkg::Q_FRAC_DEF,
	parameter int X_W      = 11,
	parameter bit SIGNED_Y = 1'b1
) (
	input  logic [aoif_pkg::DATA_W-1:0] y,
	input  logic signed [X_W-1:0]       x,
	input  logic [Q_FRAC:0]             alpha,  // already clamped to one
	output logic [aoif_pkg::DATA_W-1:0] y_next
);

	localparam int DW  = aoif_pkg::DATA_W;
	localparam int AW  = Q_FRAC + 1;
	localparam int PW  = DW + 1 + AW + 1;
	localparam int XPW = X_W + AW + 1;
	localparam int SW  = ((PW > XPW) ? PW : XPW) + 1;
	localparam logic [AW-1:0] ONE = {1'b1, {Q_FRAC{1'b0}}};

	logic [AW-1:0]        keep;
	logic signed [DW:0]   y_ext;
	logic signed [PW-1:0] prod_old;
	logic signed [XPW-1:0] prod_new;
	logic signed [SW-1:0] sum;

	assign keep  = ONE - alpha;
	assign y_ext = SIGNED_Y ? $signed({y[DW-1], y}) : $signed({1'b0, y});

	assign prod_old = y_ext * $signed({1'b0, keep});
	assign prod_new = x * $signed({1'b0, alpha});

	// arithmetic shift gives floor for negative old values
	assign sum    = SW'(prod_old >>> Q_FRAC) + SW'(prod_new);
	assign y_next = sum[DW-1:0];

endmodule

[design/adc_offset_iir_filter_core.sv]
// adc offset iir filter core: offset removal, measurement filters, zero tracking
// beats pass stage one (_s1), then the queue; one beat per cycle while s_tready is high
// the filter state update sits between the input register (_s1) and a 3-entry result queue
// s_tready drops once stage one and the queue together hold three beats
// reset: arst_n clears control and filter state, zero offsets go to 524 in Q format
// depends on aoif_pkg and aoif_filter_step
module adc_offset_iir_filter_core #(
	parameter int Q_FRAC      = aoif_pkg::Q_FRAC_DEF,
	parameter int SAMPLE_BITS = aoif_pkg::SAMPLE_BITS_DEF,
	parameter int IN_W        = ((4 * SAMPLE_BITS + 7) / 8) * 8,
	parameter int OUT_W       = ((5 * aoif_pkg::DATA_W + SAMPLE_BITS + 7) / 8) * 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [IN_W-1:0]               s_tdata,   // sample_a, sample_b, sample_c, sample_ext
	input  logic [0:0]                    s_tuser,   // mode
	// result stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [OUT_W-1:0]              m_tdata,   // meas_a, meas_b, meas_c, ext_value,
	                                                 // zero_a, zero_b
	// register port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [aoif_pkg::APB_AW-1:0]   paddr,
	input  logic [aoif_pkg::APB_DW-1:0]   pwdata,
	output logic [aoif_pkg::APB_DW-1:0]   prdata,
	output logic                          pready
);

	localparam int DW    = aoif_pkg::DATA_W;
	localparam int SB    = SAMPLE_BITS;
	localparam int AW    = Q_FRAC + 1;
	localparam int ZI_W  = DW - Q_FRAC;                      // integer part of a zero offset
	localparam int X_W   = ((SB > ZI_W) ? SB : ZI_W) + 1;   // corrected sample, signed
	localparam int RES_W = 5 * DW + SB;
	localparam logic [31:0] ZERO_RST_W = 32'(aoif_pkg::ZERO_INT_RST) << Q_FRAC;
	localparam logic [DW-1:0] ZERO_RST = ZERO_RST_W[DW-1:0];
	localparam logic [DW:0]   ONE_Q    = (DW+1)'(1) << Q_FRAC;

	// ---------------- configuration registers ----------------
	logic [aoif_pkg::ALPHA_W-1:0]  meas_alpha_q;
	logic [aoif_pkg::ALPHA_W-1:0]  zero_alpha_q;
	logic [aoif_pkg::OFFSET_W-1:0] offset_c_q;
	logic                          cfg_wr;
	aoif_pkg::reg_idx_t            cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	// word address; low byte bits are ignored
	assign cfg_idx = aoif_pkg::reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meas_alpha_q <= aoif_pkg::MEAS_ALPHA_RST;
			zero_alpha_q <= aoif_pkg::ZERO_ALPHA_RST;
			offset_c_q   <= '0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				aoif_pkg::REG_MEAS_ALPHA: meas_alpha_q <= pwdata[aoif_pkg::ALPHA_W-1:0];
				aoif_pkg::REG_ZERO_ALPHA: zero_alpha_q <= pwdata[aoif_pkg::ALPHA_W-1:0];
				aoif_pkg::REG_OFFSET_C:   offset_c_q   <= pwdata[aoif_pkg::OFFSET_W-1:0];
				default: ;  // unmapped register, write dropped
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			aoif_pkg::REG_MEAS_ALPHA: prdata = 32'(meas_alpha_q);
			aoif_pkg::REG_ZERO_ALPHA: prdata = 32'(zero_alpha_q);
			aoif_pkg::REG_OFFSET_C:   prdata = 32'(offset_c_q);
			default:                  prdata = '0;
		endcase
	end

	// weights above one are clamped to one
	logic [AW-1:0] meas_alpha_c;
	logic [AW-1:0] zero_alpha_c;

	assign meas_alpha_c = ((DW+1)'(meas_alpha_q) > ONE_Q) ? ONE_Q[AW-1:0] : AW'(meas_alpha_q);
	assign zero_alpha_c = ((DW+1)'(zero_alpha_q) > ONE_Q) ? ONE_Q[AW-1:0] : AW'(zero_alpha_q);

	// ---------------- input register ----------------
	logic          s_accept;
	logic          valid_s1;
	logic          mode_s1;
	logic [SB-1:0] samp_a_s1;
	logic [SB-1:0] samp_b_s1;
	logic [SB-1:0] samp_c_s1;
	logic [SB-1:0] samp_ext_s1;
	logic [1:0]    q_cnt_q;
	logic [2:0]    occupancy;

	// queue slots plus the beat held in stage one never exceed three
	assign occupancy = 3'(q_cnt_q) + 3'(valid_s1);
	assign s_tready  = (occupancy <= 3'd2);
	assign s_accept  = s_tvalid & s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= s_accept;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			mode_s1     <= s_tuser[0];
			samp_a_s1   <= s_tdata[SB-1:0];
			samp_b_s1   <= s_tdata[2*SB-1:SB];
			samp_c_s1   <= s_tdata[3*SB-1:2*SB];
			samp_ext_s1 <= s_tdata[4*SB-1:3*SB];
		end
	end

	// ---------------- filter state and update ----------------
	logic [DW-1:0] filt_q [3];
	logic [DW-1:0] zero_q [2];
	logic [SB-1:0] last_raw_q [2];
	logic [SB-1:0] ext_q;

	logic [DW-1:0] zero_sel [3];
	logic [SB-1:0] samp_sel [3];
	logic signed [X_W-1:0] x_corr [3];
	logic [DW-1:0] filt_next [3];
	logic [DW-1:0] zero_next [2];

	assign zero_sel[0] = zero_q[0];
	assign zero_sel[1] = zero_q[1];
	assign zero_sel[2] = offset_c_q;
	assign samp_sel[0] = samp_a_s1;
	assign samp_sel[1] = samp_b_s1;
	assign samp_sel[2] = samp_c_s1;

	for (genvar i = 0; i < 3; i++) begin : g_meas
		// remove the integer part of the zero offset
		assign x_corr[i] = $signed({1'b0, (X_W-1)'(samp_sel[i])})
			- $signed({1'b0, (X_W-1)'(zero_sel[i] >> Q_FRAC)});

		aoif_filter_step #(
			.Q_FRAC   (Q_FRAC),
			.X_W      (X_W),
			.SIGNED_Y (1'b1)
		) u_meas (
			.y      (filt_q[i]),
			.x      (x_corr[i]),
			.alpha  (meas_alpha_c),
			.y_next (filt_next[i])
		);
	end

	for (genvar j = 0; j < 2; j++) begin : g_zero
		// zero tracking runs on the last raw sample, unsigned state
		aoif_filter_step #(
			.Q_FRAC   (Q_FRAC),
			.X_W      (X_W),
			.SIGNED_Y (1'b0)
		) u_zero (
			.y      (zero_q[j]),
			.x      ($signed({1'b0, (X_W-1)'(last_raw_q[j])})),
			.alpha  (zero_alpha_c),
			.y_next (zero_next[j])
		);
	end

	logic frame_upd;
	logic zero_upd;

	assign frame_upd = valid_s1 & ~mode_s1;
	assign zero_upd  = valid_s1 & mode_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filt_q[0]     <= '0;
			filt_q[1]     <= '0;
			filt_q[2]     <= '0;
			zero_q[0]     <= ZERO_RST;
			zero_q[1]     <= ZERO_RST;
			last_raw_q[0] <= '0;
			last_raw_q[1] <= '0;
			ext_q         <= '0;
		end else if (frame_upd) begin
			filt_q[0]     <= filt_next[0];
			filt_q[1]     <= filt_next[1];
			filt_q[2]     <= filt_next[2];
			last_raw_q[0] <= samp_a_s1;
			last_raw_q[1] <= samp_b_s1;
			ext_q         <= samp_ext_s1;
		end else if (zero_upd) begin
			zero_q[0]     <= zero_next[0];
			zero_q[1]     <= zero_next[1];
		end
	end

	// result beat reflects the state after this update
	logic [RES_W-1:0] result;

	always_comb begin
		if (frame_upd) begin
			result = {zero_q[1], zero_q[0], samp_ext_s1,
				filt_next[2], filt_next[1], filt_next[0]};
		end else begin
			result = {zero_next[1], zero_next[0], ext_q, filt_q[2], filt_q[1], filt_q[0]};
		end
	end

	// ---------------- result queue ----------------
	logic [RES_W-1:0] q_mem [3];
	logic [1:0]       wr_ptr_q;
	logic [1:0]       rd_ptr_q;
	logic             q_push;
	logic             q_pop;

	assign q_push   = valid_s1;
	assign m_tvalid = (q_cnt_q != 2'd0);
	assign q_pop    = m_tvalid & m_tready;
	assign m_tdata  = OUT_W'(q_mem[rd_ptr_q]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			q_cnt_q  <= '0;
		end else begin
			if (q_push) begin
				wr_ptr_q <= (wr_ptr_q == 2'd2) ? 2'd0 : wr_ptr_q + 2'd1;
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == 2'd2) ? 2'd0 : rd_ptr_q + 2'd1;
			end
			case ({q_push, q_pop})
				2'b10:   q_cnt_q <= q_cnt_q + 2'd1;
				2'b01:   q_cnt_q <= q_cnt_q - 2'd1;
				default: ;  // both or neither, count holds
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_push) begin
			q_mem[wr_ptr_q] <= result;
		end
	end

	// ---------------- assertions ----------------
	// queue plus stage one never hold more than three beats
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		occupancy <= 3'd3)
		else $error("result queue overflow");

	// an accepted beat always produces a queue push in the next cycle
	a_accept_push: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept |=> q_push)
		else $error("accepted beat not pushed");

	// a zero tracking beat leaves the measurement filters alone
	a_zero_keeps_meas: assert property (@(posedge clk) disable iff (!arst_n)
		zero_upd |=> ($stable(filt_q[0]) && $stable(filt_q[1]) && $stable(filt_q[2])))
		else $error("zero tracking changed measurement state");

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// testbench for adc_offset_iir_filter_core: random and directed frames on the sample stream,
// results checked against an in-bench model of the offset filters and zero tracking
// depends on aoif_pkg and the core's rtl only
module tb;
	import aoif_pkg::*;

	localparam int QF    = Q_FRAC_DEF;
	localparam int SB    = SAMPLE_BITS_DEF;
	localparam int ONE_Q = 1 << QF;
	localparam int IN_W  = ((4 * SB + 7) / 8) * 8;
	localparam int OUT_W = ((5 * DATA_W + SB + 7) / 8) * 8;

	// no register decodes here, whatever the low address bits
	localparam logic [APB_AW-1:0] ADDR_UNUSED_A = 4'd12;
	localparam logic [APB_AW-1:0] ADDR_UNUSED_B = 4'd15;

	localparam logic MODE_FRAME = 1'b0;
	localparam logic MODE_TRACK = 1'b1;

	typedef struct packed {
		logic          mode;
		logic [SB-1:0] samp_a;
		logic [SB-1:0] samp_b;
		logic [SB-1:0] samp_c;
		logic [SB-1:0] samp_ext;
	} frame_in_t;

	typedef struct packed {
		logic [DATA_W-1:0] meas_a;
		logic [DATA_W-1:0] meas_b;
		logic [DATA_W-1:0] meas_c;
		logic [SB-1:0]     ext_value;
		logic [DATA_W-1:0] zero_a;
		logic [DATA_W-1:0] zero_b;
	} frame_out_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata = '0;   // sample_a, sample_b, sample_c, sample_ext
	logic [0:0]       s_tuser = '0;   // mode
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;        // meas_a, meas_b, meas_c, ext_value, zero_a, zero_b

	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [APB_DW-1:0] pwdata = '0;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	adc_offset_iir_filter_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #5 clk = ~clk;

	// register shadow, written alongside every write to a mapped register
	logic [ALPHA_W-1:0]  cfg_meas_alpha = MEAS_ALPHA_RST;
	logic [ALPHA_W-1:0]  cfg_zero_alpha = ZERO_ALPHA_RST;
	logic [OFFSET_W-1:0] cfg_offset_c   = '0;

	// filter state of the model
	logic [DATA_W-1:0] filt_state [3] = '{default: '0};
	logic [DATA_W-1:0] zero_state [2] = '{default: DATA_W'(ZERO_INT_RST << QF)};
	logic [SB-1:0]     raw_latest [2] = '{default: '0};
	logic [SB-1:0]     ext_latest     = '0;

	frame_in_t  frames_to_send [$];
	frame_out_t expected_frames [$];
	frame_in_t  frame_on_bus;
	frame_out_t frame_prediction;

	int unsigned idle_pct  = 0;  // sender gap chance per cycle, percent
	int unsigned stall_pct = 0;  // receiver stall chance per cycle, percent
	int unsigned mismatch_count = 0;

	// weights above one in q format act as exactly one
	function automatic longint weight_of(logic [ALPHA_W-1:0] w);
		return (w > ONE_Q) ? longint'(ONE_Q) : longint'(w);
	endfunction

	// signed filter step; arithmetic shift of a signed longint floors
	function automatic logic [DATA_W-1:0] ema_signed(logic [DATA_W-1:0] y, longint x, longint a);
		longint prod;
		longint sum;
		prod = longint'($signed(y)) * (ONE_Q - a);
		sum  = (prod >>> QF) + x * a;
		return sum[DATA_W-1:0];
	endfunction

	// zero tracking step; y is unsigned here
	function automatic logic [DATA_W-1:0] ema_unsigned(logic [DATA_W-1:0] y, longint x, longint a);
		longint prod;
		longint sum;
		prod = longint'(y) * (ONE_Q - a);
		sum  = (prod >> QF) + x * a;
		return sum[DATA_W-1:0];
	endfunction

	// advance the model by one accepted beat and give the result it must produce
	task automatic filter_frame(input frame_in_t f, output frame_out_t r);
		logic [SB-1:0]     raw [3];
		logic [DATA_W-1:0] zero [3];
		longint            a;
		if (f.mode == MODE_FRAME) begin
			a = weight_of(cfg_meas_alpha);
			raw[0] = f.samp_a;
			raw[1] = f.samp_b;
			raw[2] = f.samp_c;
			zero[0] = zero_state[0];
			zero[1] = zero_state[1];
			zero[2] = cfg_offset_c;
			for (int i = 0; i < 3; i++) begin
				// only the integer part of the offset is removed
				filt_state[i] = ema_signed(filt_state[i],
					longint'(raw[i]) - longint'(zero[i] >> QF), a);
			end
			raw_latest[0] = f.samp_a;
			raw_latest[1] = f.samp_b;
			ext_latest    = f.samp_ext;
		end else begin
			// samples of a tracking beat are ignored
			a = weight_of(cfg_zero_alpha);
			zero_state[0] = ema_unsigned(zero_state[0], longint'(raw_latest[0]), a);
			zero_state[1] = ema_unsigned(zero_state[1], longint'(raw_latest[1]), a);
		end
		r.meas_a    = filt_state[0];
		r.meas_b    = filt_state[1];
		r.meas_c    = filt_state[2];
		r.ext_value = ext_latest;
		r.zero_a    = zero_state[0];
		r.zero_b    = zero_state[1];
	endtask

	// sample stream driver: takes a new beat when the bus is free, with random gaps (idle_pct)
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				filter_frame(frame_on_bus, frame_prediction);
				expected_frames.push_back(frame_prediction);
			end
			if (!s_tvalid || s_tready) begin
				if (frames_to_send.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
					frame_on_bus = frames_to_send.pop_front();
					s_tdata  <= {frame_on_bus.samp_ext, frame_on_bus.samp_c,
						frame_on_bus.samp_b, frame_on_bus.samp_a};
					s_tuser  <= frame_on_bus.mode;
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(input string name, input logic [DATA_W-1:0] exp_v,
		input logic [DATA_W-1:0] got_v);
		if (exp_v !== got_v) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, got_v);
			mismatch_count++;
		end
	endtask

	// result monitor: random back-pressure, every beat checked against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		frame_out_t exp_f;
		frame_out_t got_f;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= stall_pct);
			if (m_tvalid && m_tready) begin
				got_f.meas_a    = m_tdata[15:0];
				got_f.meas_b    = m_tdata[31:16];
				got_f.meas_c    = m_tdata[47:32];
				got_f.ext_value = m_tdata[57:48];
				got_f.zero_a    = m_tdata[73:58];
				got_f.zero_b    = m_tdata[89:74];
				if (expected_frames.size() == 0) begin
					$display("%0t: unexpected result beat, expected none, actual %h",
						$time, got_f);
					mismatch_count++;
				end else begin
					exp_f = expected_frames.pop_front();
					check_field("meas_a", exp_f.meas_a, got_f.meas_a);
					check_field("meas_b", exp_f.meas_b, got_f.meas_b);
					check_field("meas_c", exp_f.meas_c, got_f.meas_c);
					check_field("ext_value", DATA_W'(exp_f.ext_value), DATA_W'(got_f.ext_value));
					check_field("zero_a", exp_f.zero_a, got_f.zero_a);
					check_field("zero_b", exp_f.zero_b, got_f.zero_b);
				end
			end
		end
	end

	// one apb transfer: setup cycle, then access until pready
	task automatic apb_access(input logic wr, input logic [APB_AW-1:0] addr,
		input logic [APB_DW-1:0] wdata, output logic [APB_DW-1:0] rdata);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// write a register with random junk above its width, update the shadow
	task automatic write_reg(input reg_idx_t idx, input int unsigned value);
		logic [APB_DW-1:0] wdata;
		logic [APB_DW-1:0] unused;
		wdata = $urandom;
		case (idx)
			REG_MEAS_ALPHA: begin
				wdata[ALPHA_W-1:0] = value[ALPHA_W-1:0];
				cfg_meas_alpha = value[ALPHA_W-1:0];
			end
			REG_ZERO_ALPHA: begin
				wdata[ALPHA_W-1:0] = value[ALPHA_W-1:0];
				cfg_zero_alpha = value[ALPHA_W-1:0];
			end
			REG_OFFSET_C: begin
				wdata[OFFSET_W-1:0] = value[OFFSET_W-1:0];
				cfg_offset_c = value[OFFSET_W-1:0];
			end
			default: ;
		endcase
		apb_access(1'b1, {idx, 2'b00}, wdata, unused);
	endtask

	task automatic check_reg(input reg_idx_t idx, input logic [APB_DW-1:0] exp_v);
		logic [APB_DW-1:0] rdata;
		apb_access(1'b0, {idx, 2'b00}, '0, rdata);
		if (rdata !== exp_v) begin
			$display("%0t: register %s readback mismatch, expected %h, actual %h",
				$time, idx.name(), exp_v, rdata);
			mismatch_count++;
		end
	endtask

	task automatic set_and_check(input int unsigned meas_w, input int unsigned zero_w,
		input int unsigned off_c);
		write_reg(REG_MEAS_ALPHA, meas_w);
		write_reg(REG_ZERO_ALPHA, zero_w);
		write_reg(REG_OFFSET_C, off_c);
		check_reg(REG_MEAS_ALPHA, APB_DW'(cfg_meas_alpha));
		check_reg(REG_ZERO_ALPHA, APB_DW'(cfg_zero_alpha));
		check_reg(REG_OFFSET_C, APB_DW'(cfg_offset_c));
	endtask

	// block is idle once nothing is queued, on the bus or still owed
	// checked at the falling edge so the driver's updates have settled
	task automatic wait_idle();
		while (frames_to_send.size() != 0 || s_tvalid || expected_frames.size() != 0)
			@(negedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic push_frame(input logic mode, input int unsigned a, input int unsigned b,
		input int unsigned c, input int unsigned ext);
		frame_in_t f;
		f.mode     = mode;
		f.samp_a   = a[SB-1:0];
		f.samp_b   = b[SB-1:0];
		f.samp_c   = c[SB-1:0];
		f.samp_ext = ext[SB-1:0];
		frames_to_send.push_back(f);
	endtask

	// rails show up often, the rest is spread over the full range
	function automatic int unsigned rand_sample();
		case ($urandom_range(0, 7))
			0:       return 0;
			1:       return (1 << SB) - 1;
			default: return $urandom_range(0, (1 << SB) - 1);
		endcase
	endfunction

	initial begin
		logic [APB_DW-1:0] unused;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values of the registers
		check_reg(REG_MEAS_ALPHA, APB_DW'(MEAS_ALPHA_RST));
		check_reg(REG_ZERO_ALPHA, APB_DW'(ZERO_ALPHA_RST));
		check_reg(REG_OFFSET_C, '0);

		// directed, reset weights: rails, tracking beats with junk samples
		push_frame(MODE_FRAME, 0, 0, 0, 0);
		push_frame(MODE_FRAME, 1023, 1023, 1023, 1023);
		push_frame(MODE_TRACK, 1023, 0, 1023, 0);
		push_frame(MODE_FRAME, 0, 1023, 0, 1023);
		push_frame(MODE_TRACK, 0, 0, 0, 0);
		push_frame(MODE_FRAME, 524, 524, 0, 512);
		push_frame(MODE_FRAME, 1023, 0, 511, 0);
		wait_idle();

		// weight above one clamps, full zero tracking, largest channel c offset
		set_and_check(127, 64, 65535);
		push_frame(MODE_TRACK, 5, 6, 7, 8);
		push_frame(MODE_FRAME, 1023, 1023, 1023, 1023);
		push_frame(MODE_FRAME, 0, 0, 0, 0);
		push_frame(MODE_TRACK, 1023, 1023, 1023, 1023);
		push_frame(MODE_FRAME, 1023, 0, 1023, 0);
		push_frame(MODE_FRAME, 512, 1, 1022, 341);
		wait_idle();

		// zero weights freeze every filter; stray writes to unmapped addresses are dropped
		set_and_check(0, 0, 32768);
		apb_access(1'b1, ADDR_UNUSED_A, '1, unused);
		apb_access(1'b1, ADDR_UNUSED_B, $urandom, unused);
		check_reg(REG_MEAS_ALPHA, APB_DW'(cfg_meas_alpha));
		check_reg(REG_ZERO_ALPHA, APB_DW'(cfg_zero_alpha));
		check_reg(REG_OFFSET_C, APB_DW'(cfg_offset_c));
		push_frame(MODE_FRAME, 1023, 1023, 1023, 682);
		push_frame(MODE_TRACK, 0, 1023, 0, 1023);
		push_frame(MODE_FRAME, 0, 0, 0, 0);
		push_frame(MODE_FRAME, 300, 700, 100, 900);
		wait_idle();

		// random phases, each with its own setting; the four idling and stall patterns repeat
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: set_and_check(MEAS_ALPHA_RST, ZERO_ALPHA_RST, 0);
				1: set_and_check(64, 64, 65535);
				2: set_and_check(0, 0, $urandom_range(0, 65535));
				3: set_and_check(127, 127, $urandom_range(0, 65535));
				5: set_and_check(1, 2, ZERO_INT_RST << QF);
				6: set_and_check(65, 0, 0);
				default: set_and_check($urandom_range(0, 127), $urandom_range(0, 127),
					$urandom_range(0, 65535));
			endcase
			case (ph % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 83; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 83; end
				default: begin idle_pct = 20; stall_pct = 20; end
			endcase
			for (int n = 0; n < 140; n++) begin
				// hold off mid-phase until the core has drained completely
				if (ph == 2 && n == 70)
					wait_idle();
				push_frame(($urandom_range(0, 3) == 0) ? MODE_TRACK : MODE_FRAME,
					rand_sample(), rand_sample(), rand_sample(), rand_sample());
			end
			wait_idle();
		end

		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && expected_frames.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#4_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

[adc_offset_iir_filter_core.f]
design/aoif_pkg.sv
design/aoif_filter_step.sv
design/adc_offset_iir_filter_core.sv
tb/tb.sv
